/* rtl/core/isc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package isc_pkg;

  // limits of the checked program
  localparam int unsigned MAX_OP_SIZE     = 64;
  localparam int unsigned REG_FILE_WORDS  = 4096;
  localparam int unsigned MAX_PROGRAM_LEN = 16383;

  // field widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned WORD_W  = 17;
  localparam int unsigned SIZE_W  = 8;
  localparam int unsigned CNT_W   = 14;
  localparam int unsigned STAT_W  = 4;
  localparam int unsigned VERD_W  = 3;

  // stream data widths, padded to whole bytes
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned OUT_DATA_W  = 72;
  localparam int unsigned CAP_RESET   = 16383;

  // one bit wider than a word, for the bound compares
  localparam logic [WORD_W:0] RF_WORDS_X    = (WORD_W + 1)'(REG_FILE_WORDS);
  localparam logic [SIZE_W-1:0] MAX_SIZE_C  = SIZE_W'(MAX_OP_SIZE);
  localparam logic [CNT_W-1:0] MAX_LEN_C    = CNT_W'(MAX_PROGRAM_LEN);
  localparam logic [CNT_W-1:0] CNT_SAT      = {CNT_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_FILL  = 2'd0,
    KIND_MAC   = 2'd1,
    KIND_RDACC = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 4'd0,
    ST_FILL_SIZE    = 4'd1,
    ST_FILL_OVERRUN = 4'd2,
    ST_NO_FILL      = 4'd3,
    ST_SIZE_MISMATCH = 4'd4,
    ST_WORD_PAST_END = 4'd5,
    ST_NOT_CONTIG   = 4'd6,
    ST_UNDRAINED    = 4'd7,
    ST_FULL         = 4'd8
  } status_e;

  typedef enum logic [VERD_W-1:0] {
    VD_VALID     = 3'd0,
    VD_EARLIER   = 3'd1,
    VD_EMPTY     = 3'd2,
    VD_TOO_LONG  = 3'd3,
    VD_NO_END    = 3'd4,
    VD_UNDRAINED = 3'd5
  } verdict_e;

  typedef struct packed {
    kind_e             kind;
    logic [WORD_W-1:0] result_word;
    logic [SIZE_W-1:0] op_size;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  item_count;
    logic [SIZE_W-1:0] fill_size;
    logic [CNT_W-1:0]  undrained_count;
    logic              run_seen;
    logic [WORD_W-1:0] run_low;
    logic [WORD_W-1:0] run_high;
    logic              error_seen;
    logic              last_was_end;
  } chk_state_t;

  typedef struct packed {
    status_e           status;
    logic [CNT_W-1:0]  item_index;
    logic [CNT_W-1:0]  pending_accumulates;
    logic              run_valid;
    logic [WORD_W-1:0] run_first;
    logic [WORD_W-1:0] run_last;
    verdict_e          verdict;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/instruction_sequence_checker_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel    | direction | handshake                  | payload
// -----------+-----------+----------------------------+----------------------------------
// s_axis     | in        | s_axis_tvalid_i/tready_o   | tuser kind, tdata word + op_size
// m_axis     | out       | m_axis_tvalid_o/tready_i   | tdata status .. verdict
// cfg        | in        | cfg_we_i                   | cfg_wdata_i program_capacity
//
// one instruction per cycle while the output is not stalled; each item passes through
// the input register, then checker logic into the result register
// checker state updates in the same edge the result register loads, so each
// item sees the state left by the one before it
// asynchronous active-low reset clears checker state and sets capacity to its maximum
// a stalled output holds both registers; ready drops only when both are full
module instruction_sequence_checker_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write: program_capacity
  input  logic                              cfg_we_i,
  input  logic [isc_pkg::CNT_W-1:0]         cfg_wdata_i,
  // input stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [16:0] result_word, [24:17] op_size, [31:25] zero
  input  logic [isc_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // [1:0] kind
  input  logic [isc_pkg::KIND_W-1:0]        s_axis_tuser_i,
  // output stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [3:0] status, [17:4] item_index, [31:18] pending_accumulates, [32] run_valid,
  // [49:33] run_first, [66:50] run_last, [69:67] verdict, [71:70] zero
  output logic [isc_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);
  import isc_pkg::*;

  logic [CNT_W-1:0] capacity_q;
  logic             in_valid_q;
  item_t            item_q;
  logic             out_valid_q;
  result_t          result_q;
  chk_state_t       state_q;
  chk_state_t       state_d;
  result_t          result_d;
  logic             advance;
  logic             in_take;

  // result register frees when empty or being taken this cycle
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CNT_W'(CAP_RESET);
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.kind        <= kind_e'(s_axis_tuser_i);
      item_q.result_word <= s_axis_tdata_i[WORD_W-1:0];
      item_q.op_size     <= s_axis_tdata_i[WORD_W+SIZE_W-1:WORD_W];
    end
  end

  isc_eval u_eval (
    .item_i     (item_q),
    .state_i    (state_q),
    .capacity_i (capacity_q),
    .state_o    (state_d),
    .result_o   (result_d)
  );

  // checker state commits together with the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (in_valid_q && advance) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00,
                            result_q.verdict,
                            result_q.run_last,
                            result_q.run_first,
                            result_q.run_valid,
                            result_q.pending_accumulates,
                            result_q.item_index,
                            result_q.status};

endmodule

`default_nettype wire

/* rtl/core/isc_eval.sv */
`timescale 1ns / 1ps
`default_nettype none

module isc_eval (
  input  isc_pkg::item_t              item_i,
  input  isc_pkg::chk_state_t         state_i,
  input  logic [isc_pkg::CNT_W-1:0]   capacity_i,
  output isc_pkg::chk_state_t         state_o,
  output isc_pkg::result_t            result_o
);
  import isc_pkg::*;

  logic            full;
  logic [WORD_W:0] fill_end;
  logic [WORD_W:0] next_word;
  logic            accept;
  logic            is_end;
  status_e         status;
  chk_state_t      nxt;
  verdict_e        verdict;

  assign full      = state_i.item_count >= capacity_i;
  assign fill_end  = {1'b0, item_i.result_word} + (WORD_W + 1)'(item_i.op_size);
  assign next_word = {1'b0, state_i.run_high} + (WORD_W + 1)'(1);

  always_comb begin
    nxt    = state_i;
    status = ST_OK;
    accept = 1'b0;
    is_end = 1'b0;
    unique case (item_i.kind)
      KIND_FILL: begin
        if (item_i.op_size == '0 || item_i.op_size > MAX_SIZE_C) begin
          status = ST_FILL_SIZE;
        end else if (fill_end > RF_WORDS_X) begin
          status = ST_FILL_OVERRUN;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          accept        = 1'b1;
          nxt.fill_size = item_i.op_size;
        end
      end
      KIND_MAC: begin
        if (state_i.fill_size == '0) begin
          status = ST_NO_FILL;
        end else if (item_i.op_size != state_i.fill_size) begin
          status = ST_SIZE_MISMATCH;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          accept = 1'b1;
          if (state_i.undrained_count != CNT_SAT) begin
            nxt.undrained_count = state_i.undrained_count + CNT_W'(1);
          end
        end
      end
      KIND_RDACC: begin
        if ({1'b0, item_i.result_word} >= RF_WORDS_X) begin
          status = ST_WORD_PAST_END;
        end else begin
          // run update stands even when the item is then refused as full
          if (!state_i.run_seen) begin
            nxt.run_seen = 1'b1;
            nxt.run_low  = item_i.result_word;
            nxt.run_high = item_i.result_word;
          end else if ({1'b0, item_i.result_word} != next_word) begin
            status = ST_NOT_CONTIG;
          end else begin
            nxt.run_high = item_i.result_word;
          end
          if (status == ST_OK) begin
            if (full) begin
              status = ST_FULL;
            end else begin
              accept              = 1'b1;
              nxt.undrained_count = '0;
            end
          end
        end
      end
      KIND_END: begin
        if (state_i.undrained_count != '0) begin
          status = ST_UNDRAINED;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          accept = 1'b1;
          is_end = 1'b1;
        end
      end
      default: status = ST_OK;
    endcase

    if (accept) begin
      nxt.item_count   = state_i.item_count + CNT_W'(1);
      nxt.last_was_end = is_end;
    end
    if (status != ST_OK) begin
      nxt.error_seen = 1'b1;
    end

    if (nxt.error_seen) begin
      verdict = VD_EARLIER;
    end else if (nxt.item_count == '0) begin
      verdict = VD_EMPTY;
    end else if (nxt.item_count > MAX_LEN_C) begin
      verdict = VD_TOO_LONG;
    end else if (!nxt.last_was_end) begin
      verdict = VD_NO_END;
    end else if (nxt.undrained_count != '0) begin
      verdict = VD_UNDRAINED;
    end else begin
      verdict = VD_VALID;
    end
  end

  assign state_o                      = nxt;
  assign result_o.status              = status;
  assign result_o.item_index          = state_i.item_count;
  assign result_o.pending_accumulates = nxt.undrained_count;
  assign result_o.run_valid           = nxt.run_seen;
  assign result_o.run_first           = nxt.run_low;
  assign result_o.run_last            = nxt.run_high;
  assign result_o.verdict             = verdict;

endmodule

`default_nettype wire

/* dv/instruction_sequence_checker_core_test.sv */
`timescale 1ns / 1ps

module instruction_sequence_checker_core_test;
  import isc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES = 80;

  // tracks the program rules and keeps the results still owed by the block
  class sequence_scoreboard;
    logic [CNT_W-1:0]  capacity;
    logic [CNT_W-1:0]  count;
    logic [SIZE_W-1:0] fill;
    logic [CNT_W-1:0]  undrained;
    logic              run_on;
    logic [WORD_W-1:0] run_lo;
    logic [WORD_W-1:0] run_hi;
    logic              sticky_err;
    logic              ended;
    int unsigned       errors;
    result_t           awaited_results[$];

    function new();
      capacity   = CNT_W'(CAP_RESET);
      count      = '0;
      fill       = '0;
      undrained  = '0;
      run_on     = 1'b0;
      run_lo     = '0;
      run_hi     = '0;
      sticky_err = 1'b0;
      ended      = 1'b0;
      errors     = 0;
    endfunction

    function status_e append_item(logic is_end);
      if (count >= capacity) return ST_FULL;
      count = count + 1'b1;
      ended = is_end;
      return ST_OK;
    endfunction

    // predicts the result of one accepted instruction and advances the state
    function void accept_instruction(item_t it);
      result_t r;
      status_e st;
      r.item_index = count;
      st = ST_OK;
      case (it.kind)
        KIND_FILL: begin
          if (it.op_size == 0 || it.op_size > MAX_SIZE_C) begin
            st = ST_FILL_SIZE;
          end else if (int'(it.result_word) + int'(it.op_size) > int'(REG_FILE_WORDS)) begin
            st = ST_FILL_OVERRUN;
          end else begin
            st = append_item(1'b0);
            if (st == ST_OK) fill = it.op_size;
          end
        end
        KIND_MAC: begin
          if (fill == 0) begin
            st = ST_NO_FILL;
          end else if (it.op_size != fill) begin
            st = ST_SIZE_MISMATCH;
          end else begin
            st = append_item(1'b0);
            if (st == ST_OK && undrained != CNT_SAT) undrained = undrained + 1'b1;
          end
        end
        KIND_RDACC: begin
          // the run moves before the capacity test
          if (int'(it.result_word) >= int'(REG_FILE_WORDS)) begin
            st = ST_WORD_PAST_END;
          end else if (!run_on) begin
            run_on = 1'b1;
            run_lo = it.result_word;
            run_hi = it.result_word;
          end else if (int'(it.result_word) != int'(run_hi) + 1) begin
            st = ST_NOT_CONTIG;
          end else begin
            run_hi = it.result_word;
          end
          if (st == ST_OK) begin
            st = append_item(1'b0);
            if (st == ST_OK) undrained = '0;
          end
        end
        default: begin
          if (undrained != 0) st = ST_UNDRAINED;
          else st = append_item(1'b1);
        end
      endcase
      if (st != ST_OK) sticky_err = 1'b1;

      r.status              = st;
      r.pending_accumulates = undrained;
      r.run_valid           = run_on;
      r.run_first           = run_lo;
      r.run_last            = run_hi;
      if (sticky_err) r.verdict = VD_EARLIER;
      else if (count == 0) r.verdict = VD_EMPTY;
      else if (count > MAX_LEN_C) r.verdict = VD_TOO_LONG;
      else if (!ended) r.verdict = VD_NO_END;
      else if (undrained != 0) r.verdict = VD_UNDRAINED;
      else r.verdict = VD_VALID;
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      result_t e;
      if (awaited_results.size() == 0) begin
        $error("result transaction with nothing awaited");
        errors++;
        return;
      end
      e = awaited_results.pop_front();
      compare_field("status", e.status, d[3:0]);
      compare_field("item_index", e.item_index, d[17:4]);
      compare_field("pending_accumulates", e.pending_accumulates, d[31:18]);
      compare_field("run_valid", e.run_valid, d[32]);
      compare_field("run_first", e.run_first, d[49:33]);
      compare_field("run_last", e.run_last, d[66:50]);
      compare_field("verdict", e.verdict, d[69:67]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CNT_W-1:0]      cfg_wdata;
  logic                  s_tvalid;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [KIND_W-1:0]     s_tuser;
  logic                  m_axis_tvalid_o;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  sequence_scoreboard sb;
  int unsigned snd_idle_pct;
  int unsigned rcv_stall_pct;
  logic        hold_req;
  logic        hold_taken;
  int unsigned hold_left;
  int unsigned cycles;

  instruction_sequence_checker_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("instruction_sequence_checker_core verification failed");
      $finish;
    end
  end

  // result side: check each transaction, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_tready) sb.check_result(m_axis_tdata_o);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  function automatic item_t instr(kind_e k, int unsigned word, int unsigned size);
    item_t it;
    it.kind        = k;
    it.result_word = WORD_W'(word);
    it.op_size     = SIZE_W'(size);
    return it;
  endfunction

  // mostly legal programs with random content, the rest noise and near misses
  function automatic item_t rand_instruction();
    item_t       it;
    int unsigned roll;
    int unsigned sz;
    it.kind        = kind_e'($urandom_range(3));
    it.result_word = WORD_W'($urandom_range(131071));
    it.op_size     = SIZE_W'($urandom_range(255));
    roll = $urandom_range(99);
    if (roll < 15) return it;
    if (roll < 25) begin
      it.result_word = WORD_W'($urandom_range(REG_FILE_WORDS + 4, REG_FILE_WORDS - 70));
      it.op_size     = SIZE_W'($urandom_range(MAX_OP_SIZE + 2));
      if (it.kind == KIND_MAC && $urandom_range(1))
        it.op_size = sb.fill ^ (8'd1 << $urandom_range(7));
      if (it.kind == KIND_RDACC && $urandom_range(1))
        it.result_word = sb.run_hi + WORD_W'($urandom_range(2));
      return it;
    end
    roll = $urandom_range(99);
    if (sb.fill == 0 || roll < 15) begin
      sz = $urandom_range(MAX_OP_SIZE, 1);
      it.kind        = KIND_FILL;
      it.op_size     = SIZE_W'(sz);
      it.result_word = WORD_W'($urandom_range(REG_FILE_WORDS - sz));
    end else if (roll < 55) begin
      it.kind    = KIND_MAC;
      it.op_size = sb.fill;
    end else if (roll < 80 || sb.undrained != 0) begin
      it.kind        = KIND_RDACC;
      it.result_word = sb.run_on ? sb.run_hi + 1'b1 : WORD_W'($urandom_range(1024));
    end else begin
      it.kind = KIND_END;
    end
    return it;
  endfunction

  task automatic send_instruction(input item_t it);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= {7'd0, it.op_size, it.result_word};
    do @(posedge clk); while (!s_axis_tready_o);
    sb.accept_instruction(it);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] cap);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    sb.capacity = cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned cap, input int unsigned n,
                           input int unsigned snd, input int unsigned rcv, input logic hold);
    drain();
    write_capacity(CNT_W'(cap));
    snd_idle_pct  = snd;
    rcv_stall_pct = rcv;
    if (hold) hold_req = 1'b1;
    repeat (n) send_instruction(rand_instruction());
  endtask

  initial begin
    item_t directed[$];
    sb            = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = '0;
    m_tready      = 1'b0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_req      = 1'b0;
    hold_taken    = 1'b0;
    hold_left     = 0;
    cycles        = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a multiply-accumulate before any fill and a fully valid program exclude
    // each other in one run, so a coin decides which one this seed sees
    if ($urandom_range(1)) directed.push_back(instr(KIND_MAC, 0, 8));
    directed.push_back(instr(KIND_FILL, 0, 4));
    directed.push_back(instr(KIND_MAC, 0, 4));
    directed.push_back(instr(KIND_MAC, 0, 4));
    directed.push_back(instr(KIND_RDACC, 0, 0));
    directed.push_back(instr(KIND_END, 0, 0));
    directed.push_back(instr(KIND_MAC, 131071, 4));
    directed.push_back(instr(KIND_RDACC, 1, 255));
    directed.push_back(instr(KIND_FILL, REG_FILE_WORDS - 1, 1));
    directed.push_back(instr(KIND_FILL, REG_FILE_WORDS - MAX_OP_SIZE, MAX_OP_SIZE));
    directed.push_back(instr(KIND_MAC, 0, MAX_OP_SIZE));
    directed.push_back(instr(KIND_END, 0, 0));
    directed.push_back(instr(KIND_RDACC, 2, 0));
    directed.push_back(instr(KIND_END, 131071, 255));
    directed.push_back(instr(KIND_FILL, 0, 0));
    directed.push_back(instr(KIND_FILL, 0, MAX_OP_SIZE + 1));
    directed.push_back(instr(KIND_FILL, 131071, 255));
    directed.push_back(instr(KIND_FILL, REG_FILE_WORDS - MAX_OP_SIZE + 1, MAX_OP_SIZE));
    directed.push_back(instr(KIND_FILL, 131071, 1));
    directed.push_back(instr(KIND_MAC, 0, MAX_OP_SIZE - 1));
    directed.push_back(instr(KIND_MAC, 0, 255));
    directed.push_back(instr(KIND_RDACC, REG_FILE_WORDS, 0));
    directed.push_back(instr(KIND_RDACC, 131071, 255));
    directed.push_back(instr(KIND_RDACC, 3, 0));
    directed.push_back(instr(KIND_RDACC, 3, 0));
    directed.push_back(instr(KIND_RDACC, 0, 0));

    write_capacity(CNT_W'(CAP_RESET));
    foreach (directed[i]) send_instruction(directed[i]);
    repeat (450) send_instruction(rand_instruction());

    // capacity just above the count, so the program runs into full
    run_phase(int'(sb.count) + $urandom_range(40, 10), 450, 54, 0, 1'b0);
    // long output hold-off while the input keeps offering
    run_phase(1, 100, 0, 54, 1'b1);
    run_phase(0, 100, 37, 37, 1'b0);
    run_phase(CAP_RESET, 450, 0, 54, 1'b0);
    run_phase(int'(sb.count) + $urandom_range(200, 50), 400, 37, 37, 1'b0);

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("instruction_sequence_checker_core verification clean");
    end else begin
      $display("instruction_sequence_checker_core verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/isc_pkg.sv
rtl/core/isc_eval.sv
rtl/core/instruction_sequence_checker_core.sv
dv/instruction_sequence_checker_core_test.sv
